// ----- sv/cobs_fd_pkg.sv -----
// Shared types and constants of the COBS frame decoder.
`timescale 1ns / 1ps

package cobs_fd_pkg;

    // Code byte that opens a full group with no implied zero after it.
    localparam logic [7:0] FULL_CODE = 8'hFF;

    // Depth of the queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_CODE = 2'd1,
        ST_TRUNCATED = 2'd2,
        ST_CAPACITY  = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_frame;
    } t_in_item;

    typedef struct packed {
        logic        frame_done;
        logic [7:0]  out_byte;
        t_status     status;
        logic [15:0] frame_length;
    } t_out_item;

    // One classified input byte: an optional data result, then an optional status result.
    typedef struct packed {
        logic        has_data;
        logic [7:0]  data;
        logic        has_status;
        t_status     status;
        logic [15:0] length;
    } t_action;

endpackage

// ----- sv/cobs_fd_front.sv -----
// Front part: accepts stuffed bytes, tracks group state and classifies each byte.
`timescale 1ns / 1ps

module cobs_fd_front
    import cobs_fd_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_fifo_full,
    output logic        o_push,
    output t_action     o_action
);

    localparam int CMP_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
    localparam logic [CMP_W-1:0] CNT_MAX =
        {{(CMP_W - COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

    logic [15:0]            r_capacity;
    logic [7:0]             r_group_left, n_group_left;
    logic                   r_prev_full,  n_prev_full;
    logic                   r_at_start,   n_at_start;
    logic [COUNT_WIDTH-1:0] r_count,      n_count;
    t_status                r_error,      n_error;

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] cap_lim;
    logic [CMP_W-1:0] v_cnt;
    logic [CMP_W-1:0] need;
    logic             accept;
    t_action          act;

    assign o_in_ready = !i_fifo_full;
    assign accept     = i_in_valid && o_in_ready;
    assign cap_ext    = CMP_W'(r_capacity);
    assign cap_lim    = (cap_ext < CNT_MAX) ? cap_ext : CNT_MAX;
    assign need       = CMP_W'(i_in_item.data_byte) - CMP_W'(1);

    always_comb begin
        n_group_left   = r_group_left;
        n_prev_full    = r_prev_full;
        n_at_start     = r_at_start;
        n_error        = r_error;
        v_cnt          = CMP_W'(r_count);
        act            = '0;
        act.status     = ST_OK;

        if (r_error == ST_OK) begin
            if (r_group_left == 8'd0) begin
                // Code byte: close the previous group with its implied zero.
                if (!r_at_start && !r_prev_full) begin
                    if (v_cnt >= cap_lim) begin
                        n_error = ST_CAPACITY;
                    end else begin
                        act.has_data = 1'b1;
                        act.data     = 8'd0;
                        v_cnt        = v_cnt + CMP_W'(1);
                    end
                end
                if (n_error == ST_OK) begin
                    if (i_in_item.data_byte == 8'd0) begin
                        n_error = ST_ZERO_CODE;
                    end else if (v_cnt > cap_lim || need > cap_lim - v_cnt) begin
                        n_error = ST_CAPACITY;
                    end else begin
                        n_group_left = i_in_item.data_byte - 8'd1;
                        n_prev_full  = (i_in_item.data_byte == FULL_CODE);
                    end
                end
                n_at_start = 1'b0;
            end else begin
                // Data byte: room was reserved when the group opened.
                act.has_data = 1'b1;
                act.data     = i_in_item.data_byte;
                v_cnt        = v_cnt + CMP_W'(1);
                n_group_left = r_group_left - 8'd1;
            end
            if (i_in_item.last_in_frame && n_error == ST_OK && n_group_left != 8'd0) begin
                n_error = ST_TRUNCATED;
            end
        end

        n_count = v_cnt[COUNT_WIDTH-1:0];

        if (i_in_item.last_in_frame) begin
            act.has_status = 1'b1;
            act.status     = n_error;
            act.length     = 16'(n_count);
            n_group_left   = 8'd0;
            n_prev_full    = 1'b0;
            n_at_start     = 1'b1;
            n_count        = '0;
            n_error        = ST_OK;
        end
    end

    assign o_push   = accept && (act.has_data || act.has_status);
    assign o_action = act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= 16'hFFFF;
            r_group_left <= 8'd0;
            r_prev_full  <= 1'b0;
            r_at_start   <= 1'b1;
            r_count      <= '0;
            r_error      <= ST_OK;
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (accept) begin
                r_group_left <= n_group_left;
                r_prev_full  <= n_prev_full;
                r_at_start   <= n_at_start;
                r_count      <= n_count;
                r_error      <= n_error;
            end
        end
    end

endmodule

// ----- sv/cobs_fd_fifo.sv -----
// Short queue of classified bytes between the front and back parts.
`timescale 1ns / 1ps

module cobs_fd_fifo
    import cobs_fd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_action i_action,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_action o_action
);

    t_action              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_fill;

    assign o_full   = (r_fill == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_empty  = (r_fill == '0);
    assign o_action = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_action;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + (FIFO_AW + 1)'(1);
                2'b01:   r_fill <= r_fill - (FIFO_AW + 1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// ----- sv/cobs_fd_back.sv -----
// Back part: expands each classified byte into its results and drives the output register.
`timescale 1ns / 1ps

module cobs_fd_back
    import cobs_fd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_action   i_action,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_out_valid;
    t_out_item r_out_item;
    logic      r_pend_valid;
    t_status   r_pend_status;
    logic [15:0] r_pend_length;

    logic      slot_free;
    t_out_item data_item;
    t_out_item stat_item;

    assign slot_free = !r_out_valid || i_out_ready;
    // Pop only when no status result from the previous entry is still pending.
    assign o_pop     = slot_free && !r_pend_valid && !i_empty;

    always_comb begin
        data_item              = '0;
        data_item.out_byte     = i_action.data;
        data_item.status       = ST_OK;
        stat_item              = '0;
        stat_item.frame_done   = 1'b1;
        if (r_pend_valid) begin
            stat_item.status       = r_pend_status;
            stat_item.frame_length = r_pend_length;
        end else begin
            stat_item.status       = i_action.status;
            stat_item.frame_length = i_action.length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            if (r_pend_valid) begin
                r_out_item <= stat_item;
            end else if (!i_empty) begin
                r_out_item <= i_action.has_data ? data_item : stat_item;
            end
        end
        if (o_pop) begin
            r_pend_status <= i_action.status;
            r_pend_length <= i_action.length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (slot_free) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else begin
                r_out_valid  <= !i_empty;
                r_pend_valid <= o_pop && i_action.has_data && i_action.has_status;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- sv/cobs_frame_decoder.sv -----
// Top level of the streaming COBS frame decoder.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one stuffed
//   byte per transfer, delimiter already stripped, with last_in_frame set on
//   the final byte of each frame. Output channel (o_out_valid / i_out_ready /
//   o_out_item) carries decoded data bytes (frame_done = 0) and, after the
//   last byte of a frame, one status transfer (frame_done = 1) with the
//   error code and the decoded length.
//   i_cfg_wr_en / i_cfg_wr_data write the output capacity; write it only
//   while the decoder is idle.
// Data path and throughput:
//   An accepted byte passes through the queue and then the output register.
//   Input runs at one byte per cycle while the queue has room; each byte
//   yields up to two results, and the output register moves one per cycle
//   while the receiver is ready. A four-entry queue between the classifier
//   and the output stage absorbs the extra status transfer at a frame end.
// Reset: synchronous, active low; capacity returns to 65535, frame state to
//   start of frame, queue and output empty.
// Stalls: when i_out_ready is low the output holds; the queue fills and then
//   o_in_ready drops until the receiver drains it. Nothing is lost.

module cobs_frame_decoder
    import cobs_fd_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    logic    fifo_full;
    logic    fifo_empty;
    logic    push;
    logic    pop;
    t_action push_action;
    t_action head_action;

    // Classify each byte and track group, count and error state.
    cobs_fd_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fifo_full   (fifo_full),
        .o_push        (push),
        .o_action      (push_action)
    );

    // Decouple classification from output back pressure.
    cobs_fd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_action (push_action),
        .o_full   (fifo_full),
        .i_pop    (pop),
        .o_empty  (fifo_empty),
        .o_action (head_action)
    );

    // Expand queued entries into data and status transfers.
    cobs_fd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (fifo_empty),
        .i_action    (head_action),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
